// File: design/cpc_pkg.sv
package cpc_pkg;

   localparam int ITERATIONS_DEFAULT = 16;
   localparam int MAX_STEPS          = 24;

   // x/y carry 16 fraction bits; z is in 1/32768 degree
   localparam int XY_W   = 36;
   localparam int Z_W    = 26;
   localparam int GAIN_W = 24;

   localparam logic [GAIN_W-1:0] INV_GAIN = 24'd10188014;

   localparam logic signed [Z_W-1:0] DEG90  = 26'sd2949120;
   localparam logic signed [Z_W-1:0] DEG180 = 26'sd5898240;

   localparam logic signed [15:0] COORD_LIMIT = 16'sd32767;
   localparam logic signed [15:0] ANGLE_LIMIT = 16'sd23040;

   localparam logic CMD_TO_POLAR = 1'b0;
   localparam logic CMD_TO_CART  = 1'b1;

   typedef struct packed {
      logic                   mode;
      logic                   flip;
      logic                   zero;
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } stage_type;

   // atan(2^-i) in 1/32768 degree
   function automatic logic signed [Z_W-1:0] atan_value(input int unsigned idx);
      logic signed [Z_W-1:0] v;
      unique case (idx)
         0:  v = 26'sd1474560;
         1:  v = 26'sd870484;
         2:  v = 26'sd459940;
         3:  v = 26'sd233473;
         4:  v = 26'sd117189;
         5:  v = 26'sd58652;
         6:  v = 26'sd29333;
         7:  v = 26'sd14667;
         8:  v = 26'sd7334;
         9:  v = 26'sd3667;
         10: v = 26'sd1833;
         11: v = 26'sd917;
         12: v = 26'sd458;
         13: v = 26'sd229;
         14: v = 26'sd115;
         15: v = 26'sd57;
         16: v = 26'sd29;
         17: v = 26'sd14;
         18: v = 26'sd7;
         19: v = 26'sd4;
         20: v = 26'sd2;
         21: v = 26'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// File: design/polar_cartesian_converter_top.sv
// Accepts one item per cycle while the output register is empty or taken; an input
// fold register is followed by one CORDIC micro-rotation per pipeline stage,
// then a rounding/partial-product stage and the output register.
// The whole pipe advances together while the output register is empty or taken.
// Reset (synchronous, active high) clears all valid bits; data is not reset.
module polar_cartesian_converter_top #(
   parameter int ITERATIONS = cpc_pkg::ITERATIONS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // x_in[15:0], y_in[31:16], magnitude_in[46:32],
                                   // angle_in[62:47], zero pad[63]
   input  logic        req_tuser,  // command[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata   // x_out[15:0], y_out[31:16], magnitude_out[47:32],
                                   // angle_out[63:48]
);

   localparam int STEPS  = (ITERATIONS < cpc_pkg::MAX_STEPS) ? ITERATIONS
                                                             : cpc_pkg::MAX_STEPS;
   localparam int XY_W   = cpc_pkg::XY_W;
   localparam int Z_W    = cpc_pkg::Z_W;
   localparam int GAIN_W = cpc_pkg::GAIN_W;
   localparam int LO_W   = 17;
   localparam int HI_W   = XY_W - LO_W;
   localparam int PLO_W  = LO_W + GAIN_W;
   localparam int PHI_W  = HI_W + GAIN_W + 1;
   localparam int SUM_W  = PHI_W + LO_W;

   logic advance;
   logic accept;
   logic rsp_vld_ff;

   cpc_pkg::stage_type pipe_ff  [0:STEPS];
   logic               pipe_vld_ff [0:STEPS];

   assign advance    = !rsp_vld_ff || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   // ---------------- input stage: fold into CORDIC range ----------------
   cpc_pkg::stage_type     entry_in;
   logic signed [15:0]     x_i, y_i, a_i;
   logic [14:0]            m_i;
   logic signed [XY_W-1:0] xs, ys;
   logic [14+GAIN_W:0]     m_prod;
   logic signed [Z_W-1:0]  za;

   always_comb begin
      x_i    = req_tdata[15:0];
      y_i    = req_tdata[31:16];
      m_i    = req_tdata[46:32];
      a_i    = req_tdata[62:47];
      xs     = {{(XY_W-32){x_i[15]}}, x_i, 16'h0000};
      ys     = {{(XY_W-32){y_i[15]}}, y_i, 16'h0000};
      m_prod = m_i * cpc_pkg::INV_GAIN;
      za     = {{(Z_W-24){a_i[15]}}, a_i, 8'h00};
      entry_in.mode = req_tuser;
      entry_in.zero = (x_i == 16'sd0) && (y_i == 16'sd0);
      entry_in.flip = 1'b0;
      if (req_tuser == cpc_pkg::CMD_TO_CART) begin
         entry_in.x = XY_W'(m_prod[14+GAIN_W:8]);
         entry_in.y = '0;
         if (za > cpc_pkg::DEG90) begin
            entry_in.z    = za - cpc_pkg::DEG180;
            entry_in.flip = 1'b1;
         end else if (za < -cpc_pkg::DEG90) begin
            entry_in.z    = za + cpc_pkg::DEG180;
            entry_in.flip = 1'b1;
         end else begin
            entry_in.z = za;
         end
      end else if (x_i[15]) begin
         if (!y_i[15]) begin
            entry_in.x = ys;
            entry_in.y = -xs;
            entry_in.z = cpc_pkg::DEG90;
         end else begin
            entry_in.x = -ys;
            entry_in.y = xs;
            entry_in.z = -cpc_pkg::DEG90;
         end
      end else begin
         entry_in.x = xs;
         entry_in.y = ys;
         entry_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_vld_ff[0] <= 1'b0;
      end else if (advance) begin
         pipe_vld_ff[0] <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pipe_ff[0] <= entry_in;
      end
   end

   // ---------------- CORDIC micro-rotations ----------------
   for (genvar k = 1; k <= STEPS; k++) begin : g_step
      localparam int SH = k - 1;
      cpc_pkg::stage_type     step_in;
      logic signed [XY_W-1:0] px, py, dx, dy;
      logic signed [Z_W-1:0]  pz, at;
      logic                   neg;

      always_comb begin
         px  = pipe_ff[k-1].x;
         py  = pipe_ff[k-1].y;
         pz  = pipe_ff[k-1].z;
         dx  = py >>> SH;
         dy  = px >>> SH;
         at  = cpc_pkg::atan_value(SH);
         neg = (pipe_ff[k-1].mode == cpc_pkg::CMD_TO_CART) ? pz[Z_W-1] : (py > 0);
         step_in = pipe_ff[k-1];
         if (neg) begin
            step_in.x = px + dx;
            step_in.y = py - dy;
            step_in.z = pz + at;
         end else begin
            step_in.x = px - dx;
            step_in.y = py + dy;
            step_in.z = pz - at;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            pipe_vld_ff[k] <= 1'b0;
         end else if (advance) begin
            pipe_vld_ff[k] <= pipe_vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            pipe_ff[k] <= step_in;
         end
      end
   end

   // ---------------- rounding and gain partial products ----------------
   logic                        fin_vld_ff;
   logic                        fin_mag_en_ff, fin_mag_en_in;
   logic signed [15:0]          fin_x_ff, fin_x_in;
   logic signed [15:0]          fin_y_ff, fin_y_in;
   logic signed [15:0]          fin_a_ff, fin_a_in;
   logic [PLO_W-1:0]            fin_plo_ff, fin_plo_in;
   logic signed [PHI_W-1:0]     fin_phi_ff, fin_phi_in;

   cpc_pkg::stage_type          last;
   logic signed [XY_W-1:0]      xf, yf, xr_sum, yr_sum;
   logic signed [XY_W-17:0]     xr, yr;
   logic signed [Z_W-1:0]       zr_sum;
   logic signed [Z_W-9:0]       zr;
   logic                        is_cart, is_polar;

   always_comb begin
      last     = pipe_ff[STEPS];
      is_cart  = (last.mode == cpc_pkg::CMD_TO_CART);
      is_polar = !is_cart && !last.zero;
      xf       = last.flip ? -last.x : last.x;
      yf       = last.flip ? -last.y : last.y;
      xr_sum   = xf + XY_W'(32768);
      yr_sum   = yf + XY_W'(32768);
      xr       = xr_sum[XY_W-1:16];
      yr       = yr_sum[XY_W-1:16];
      zr_sum   = last.z + Z_W'(128);
      zr       = zr_sum[Z_W-1:8];

      if (!is_cart)                   fin_x_in = '0;
      else if (xr > cpc_pkg::COORD_LIMIT)  fin_x_in = cpc_pkg::COORD_LIMIT;
      else if (xr < -cpc_pkg::COORD_LIMIT) fin_x_in = -cpc_pkg::COORD_LIMIT;
      else                            fin_x_in = xr[15:0];

      if (!is_cart)                   fin_y_in = '0;
      else if (yr > cpc_pkg::COORD_LIMIT)  fin_y_in = cpc_pkg::COORD_LIMIT;
      else if (yr < -cpc_pkg::COORD_LIMIT) fin_y_in = -cpc_pkg::COORD_LIMIT;
      else                            fin_y_in = yr[15:0];

      if (!is_polar)                  fin_a_in = '0;
      else if (zr > cpc_pkg::ANGLE_LIMIT)  fin_a_in = cpc_pkg::ANGLE_LIMIT;
      else if (zr < -cpc_pkg::ANGLE_LIMIT) fin_a_in = -cpc_pkg::ANGLE_LIMIT;
      else                            fin_a_in = zr[15:0];

      fin_mag_en_in = is_polar;
      fin_plo_in    = last.x[LO_W-1:0] * cpc_pkg::INV_GAIN;
      fin_phi_in    = $signed(last.x[XY_W-1:LO_W]) * $signed({1'b0, cpc_pkg::INV_GAIN});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_vld_ff <= 1'b0;
      end else if (advance) begin
         fin_vld_ff <= pipe_vld_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fin_mag_en_ff <= fin_mag_en_in;
         fin_x_ff      <= fin_x_in;
         fin_y_ff      <= fin_y_in;
         fin_a_ff      <= fin_a_in;
         fin_plo_ff    <= fin_plo_in;
         fin_phi_ff    <= fin_phi_in;
      end
   end

   // ---------------- magnitude sum and output register ----------------
   logic [63:0]             rsp_data_ff, rsp_data_in;
   logic signed [SUM_W-1:0] mag_sum;
   logic signed [SUM_W-41:0] mag_r;
   logic [15:0]             mag_out;

   always_comb begin
      mag_sum = {fin_phi_ff, {LO_W{1'b0}}}
              + $signed({{(SUM_W-PLO_W){1'b0}}, fin_plo_ff})
              + (SUM_W'(1) <<< 39);
      mag_r   = mag_sum[SUM_W-1:40];
      if (!fin_mag_en_ff || mag_r < 0)         mag_out = '0;
      else if (mag_r > $signed(SUM_W'(65535))) mag_out = 16'hFFFF;
      else                                     mag_out = mag_r[15:0];
      rsp_data_in = {fin_a_ff, mag_out, fin_y_ff, fin_x_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= fin_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: design/cpc_checker.sv
module cpc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   // a stalled item stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   // input is only held off by a stalled output
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req_tready low without output stall");

   // only one mode's fields are populated
   a_mode_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[31:0] == 32'h0) || (rsp_tdata[63:32] == 32'h0))
      else $error("both Cartesian and polar outputs nonzero");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[63:48]) <= 16'sd23040)
                  && ($signed(rsp_tdata[63:48]) >= -16'sd23040))
      else $error("angle_out out of range");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

endmodule

bind polar_cartesian_converter_top cpc_checker u_cpc_checker (.*);

// File: verif/tb_polar_cartesian_converter_top.sv
module tb_polar_cartesian_converter_top;

   localparam int     ITER_COUNT  = 16;
   localparam int     STEP_COUNT  = (ITER_COUNT < 24) ? ITER_COUNT : 24;
   localparam longint GAIN_COMP   = 64'sd10188014;
   localparam longint Z_DEG90     = 64'sd2949120;
   localparam longint Z_DEG180    = 64'sd5898240;
   localparam longint MAG_HALF    = 64'sd549755813888;   // 2^39
   localparam longint ANG_MAX     = 64'sd23040;
   localparam longint XY_MAX      = 64'sd32767;
   localparam int     RANDOM_ITEMS = 2000;
   localparam int     HOLD_AFTER  = 300;
   localparam int     HOLD_CYCLES = 200;

   // atan(2^-i) in 1/32768 degree
   localparam longint ATAN_STEP [0:23] = '{
      1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
      7334, 3667, 1833, 917, 458, 229, 115, 57,
      29, 14, 7, 4, 2, 1, 0, 0
   };

   typedef struct packed {
      logic [15:0] x_out;
      logic [15:0] y_out;
      logic [15:0] magnitude_out;
      logic [15:0] angle_out;
   } coord_result_type;

   class conv_scoreboard;
      coord_result_type pending[$];
      int               errors;
      int               results_seen;

      function longint clip(longint v, longint lo, longint hi);
         return (v < lo) ? lo : ((v > hi) ? hi : v);
      endfunction

      function void rect_to_polar(longint xi, longint yi, output longint mag,
                                  output longint ang);
         longint x, y, z, t, dx, dy;
         x = xi * 65536;
         y = yi * 65536;
         z = 0;
         mag = 0;
         ang = 0;
         if (xi == 0 && yi == 0) return;
         if (x < 0) begin
            t = x;
            if (y >= 0) begin
               x = y;
               y = -t;
               z = Z_DEG90;
            end else begin
               x = -y;
               y = t;
               z = -Z_DEG90;
            end
         end
         for (int i = 0; i < STEP_COUNT; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
               x += dx;
               y -= dy;
               z += ATAN_STEP[i];
            end else begin
               x -= dx;
               y += dy;
               z -= ATAN_STEP[i];
            end
         end
         mag = clip((x * GAIN_COMP + MAG_HALF) >>> 40, 0, 65535);
         ang = clip((z + 128) >>> 8, -ANG_MAX, ANG_MAX);
      endfunction

      function void polar_to_rect(longint m, longint a, output longint xo,
                                  output longint yo);
         longint x, y, z, dx, dy;
         bit     flip;
         z = a * 256;
         y = 0;
         flip = 1'b0;
         if (z > Z_DEG90) begin
            z -= Z_DEG180;
            flip = 1'b1;
         end else if (z < -Z_DEG90) begin
            z += Z_DEG180;
            flip = 1'b1;
         end
         x = (m * GAIN_COMP) >>> 8;
         for (int i = 0; i < STEP_COUNT; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx;
               y += dy;
               z -= ATAN_STEP[i];
            end else begin
               x += dx;
               y -= dy;
               z += ATAN_STEP[i];
            end
         end
         if (flip) begin
            x = -x;
            y = -y;
         end
         xo = clip((x + 32768) >>> 16, -XY_MAX, XY_MAX);
         yo = clip((y + 32768) >>> 16, -XY_MAX, XY_MAX);
      endfunction

      function void note_input(logic cmd, logic [63:0] d);
         coord_result_type r;
         longint           xo, yo, mo, ao;
         xo = 0;
         yo = 0;
         mo = 0;
         ao = 0;
         if (cmd == cpc_pkg::CMD_TO_POLAR)
            rect_to_polar(longint'($signed(d[15:0])), longint'($signed(d[31:16])), mo, ao);
         else
            polar_to_rect(longint'(d[46:32]), longint'($signed(d[62:47])), xo, yo);
         r.x_out         = xo[15:0];
         r.y_out         = yo[15:0];
         r.magnitude_out = mo[15:0];
         r.angle_out     = ao[15:0];
         pending.push_back(r);
      endfunction

      function void flag(string field, longint exp_v, longint got_v);
         errors++;
         $error("%s: expected %0d, got %0d", field, exp_v, got_v);
      endfunction

      function void check_result(logic [63:0] d);
         coord_result_type e;
         results_seen++;
         if (pending.size() == 0) begin
            errors++;
            $error("result with no item pending: %h", d);
            return;
         end
         e = pending.pop_front();
         if (d[15:0] !== e.x_out)
            flag("x_out", $signed(e.x_out), $signed(d[15:0]));
         if (d[31:16] !== e.y_out)
            flag("y_out", $signed(e.y_out), $signed(d[31:16]));
         if (d[47:32] !== e.magnitude_out)
            flag("magnitude_out", e.magnitude_out, d[47:32]);
         if (d[63:48] !== e.angle_out)
            flag("angle_out", $signed(e.angle_out), $signed(d[63:48]));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;

   conv_scoreboard sb = new();
   int             items_sent;
   bit             held;

   polar_cartesian_converter_top #(
      .ITERATIONS (ITER_COUNT)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_input(req_tuser, req_tdata);
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata);
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [15:0] pick_coord();
      if ($urandom_range(0, 4) == 0) return 16'($urandom_range(0, 100) - 50);
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic send_item(logic cmd, logic [15:0] x, logic [15:0] y, logic [14:0] m,
                            logic [15:0] a);
      int gap;
      req_tdata  <= {1'b0, a, m, y, x};
      req_tuser  <= cmd;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      items_sent++;
      gap = (items_sent >= 1000 && items_sent < 1200) ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_polar(int x, int y);
      send_item(cpc_pkg::CMD_TO_POLAR, 16'(x), 16'(y), 15'($urandom), 16'($urandom));
   endtask

   task automatic send_cart(int m, int a);
      send_item(cpc_pkg::CMD_TO_CART, 16'($urandom), 16'($urandom), 15'(m), 16'(a));
   endtask

   // receiver: random stalls, one long hold-off once traffic is flowing
   initial begin
      int stall;
      int run;
      rsp_tready = 1'b0;
      held = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (!held && sb.results_seen >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            stall = pick_gap();
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
         end
         rsp_tready <= 1'b1;
         run = $urandom_range(1, 30);
         repeat (run) @(negedge clock);
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      items_sent = 0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Cartesian to polar: origin, extremes, left half-plane on both sides
      send_polar(0, 0);
      send_polar(32767, 0);
      send_polar(-32768, -32768);
      send_polar(32767, 32767);
      send_polar(-32767, 0);
      send_polar(-100, -1);
      send_polar(0, 32767);
      send_polar(0, -32768);
      send_polar(-32768, 32767);
      send_polar(1, -1);
      send_polar(3, 4);
      // polar to Cartesian: zero radius, quadrant folding, angles past 180 degrees
      send_cart(0, 0);
      send_cart(32767, 0);
      send_cart(32767, 23040);
      send_cart(32767, -23040);
      send_cart(32767, 11520);
      send_cart(32767, 11521);
      send_cart(32767, -11521);
      send_cart(32767, 32767);
      send_cart(32767, -32768);
      send_cart(1, 5760);
      send_cart(20000, -7000);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         logic [14:0] m;
         logic [15:0] a;
         m = ($urandom_range(0, 4) == 0) ? 15'($urandom_range(0, 40)) : 15'($urandom);
         a = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 46080) - 23040)
                                        : 16'($urandom);
         send_item(1'($urandom), pick_coord(), pick_coord(), m, a);
      end
      req_tvalid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (ITER_COUNT + 10) @(posedge clock);
      if (sb.errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #(20 * 1000000);
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// File: sim.f
design/cpc_pkg.sv
design/polar_cartesian_converter_top.sv
design/cpc_checker.sv
verif/tb_polar_cartesian_converter_top.sv
